/* sv/uec_pkg.sv */
// Package for the URL extension classifier: file-type codes, the extension
// table and the prefix-match function. No dependencies.
package uec_pkg;

  localparam int EXT_CAP     = 5;
  localparam int EXT_ENTRIES = 11;
  localparam int CNT_W       = $clog2(EXT_CAP + 1);

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [3:0] FT_UNSUPPORTED = 4'd0;
  localparam logic [3:0] FT_CGI         = 4'd1;
  localparam logic [3:0] FT_HTML        = 4'd2;
  localparam logic [3:0] FT_JPG         = 4'd3;
  localparam logic [3:0] FT_PNG         = 4'd4;
  localparam logic [3:0] FT_GIF         = 4'd5;
  localparam logic [3:0] FT_CSS         = 4'd6;
  localparam logic [3:0] FT_ICO         = 4'd7;
  localparam logic [3:0] FT_JS          = 4'd8;
  localparam logic [3:0] FT_TXT         = 4'd9;

  typedef logic [EXT_CAP-1:0][7:0] ext_t;

  typedef struct packed {
    ext_t ext;
    logic single_slash;
  } cap_t;

  localparam logic [7:0] EXT_TEXT [EXT_ENTRIES][EXT_CAP] = '{
    '{"c", "g", "i", 8'h00, 8'h00},
    '{"h", "t", "m", "l", 8'h00},
    '{"h", "t", "m", 8'h00, 8'h00},
    '{"s", "h", "t", "m", "l"},
    '{"j", "p", "g", 8'h00, 8'h00},
    '{"p", "n", "g", 8'h00, 8'h00},
    '{"g", "i", "f", 8'h00, 8'h00},
    '{"c", "s", "s", 8'h00, 8'h00},
    '{"i", "c", "o", 8'h00, 8'h00},
    '{"j", "s", 8'h00, 8'h00, 8'h00},
    '{"t", "x", "t", 8'h00, 8'h00}
  };

  localparam logic [2:0] EXT_SIZE [EXT_ENTRIES] = '{
    3'd3, 3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3
  };

  localparam logic [3:0] EXT_CODE [EXT_ENTRIES] = '{
    FT_CGI, FT_HTML, FT_HTML, FT_HTML, FT_JPG, FT_PNG, FT_GIF, FT_CSS,
    FT_ICO, FT_JS, FT_TXT
  };

  // The earliest matching entry wins, so the scan runs from the end.
  function automatic logic [3:0] classify(ext_t ext);
    logic [3:0] code;
    logic       same;
    code = FT_UNSUPPORTED;
    for (int i = EXT_ENTRIES - 1; i >= 0; i--) begin
      same = 1'b1;
      for (int k = 0; k < EXT_CAP; k++) begin
        if ((3'(k) < EXT_SIZE[i]) && (ext[k] != EXT_TEXT[i][k])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        code = EXT_CODE[i];
      end
    end
    return code;
  endfunction

endpackage

/* sv/uec_if.sv */
// Valid/ready channel interfaces for path bytes and file-type results.
// Depends on nothing.
interface uec_path_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       last_byte;

  modport source (output valid, output path_byte, output last_byte, input ready);
  modport sink (input valid, input path_byte, input last_byte, output ready);
endinterface

interface uec_type_if;
  logic       valid;
  logic       ready;
  logic [3:0] file_type;

  modport source (output valid, output file_type, input ready);
  modport sink (input valid, input file_type, output ready);
endinterface

/* sv/uec_capture.sv */
// Per-path capture state: dot tracking, extension byte capture and the
// single-slash check. Depends on uec_pkg.
module uec_capture (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    path_byte,
  input  logic          last_byte,
  output uec_pkg::cap_t cap
);

  logic                      dot_found_r, dot_found_nxt;
  logic                      zero_seen_r, zero_seen_nxt;
  logic [uec_pkg::CNT_W-1:0] count_r, count_nxt;
  uec_pkg::ext_t             ext_r, ext_nxt;
  logic [1:0]                bytes_seen_r, bytes_seen_nxt;
  logic                      first_slash_r, first_slash_nxt;

  always_comb begin
    dot_found_nxt   = dot_found_r;
    zero_seen_nxt   = zero_seen_r;
    count_nxt       = count_r;
    ext_nxt         = ext_r;
    first_slash_nxt = (bytes_seen_r == 2'd0) ? (path_byte == uec_pkg::CHAR_SLASH)
                                             : first_slash_r;
    bytes_seen_nxt  = (bytes_seen_r < 2'd2) ? bytes_seen_r + 2'd1 : bytes_seen_r;
    if (dot_found_r) begin
      if (count_r < uec_pkg::CNT_W'(uec_pkg::EXT_CAP)) begin
        for (int i = 0; i < uec_pkg::EXT_CAP; i++) begin
          if (count_r == uec_pkg::CNT_W'(i)) begin
            ext_nxt[i] = path_byte;
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else if (path_byte == uec_pkg::CHAR_DOT) begin
      if (!zero_seen_r) begin
        dot_found_nxt = 1'b1;
      end
    end else if (path_byte == uec_pkg::CHAR_NUL) begin
      zero_seen_nxt = 1'b1;
    end
  end

  assign cap.ext          = ext_nxt;
  assign cap.single_slash = (bytes_seen_r == 2'd0) && (path_byte == uec_pkg::CHAR_SLASH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_found_r   <= 1'b0;
      zero_seen_r   <= 1'b0;
      count_r       <= '0;
      ext_r         <= '0;
      bytes_seen_r  <= 2'd0;
      first_slash_r <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        dot_found_r   <= 1'b0;
        zero_seen_r   <= 1'b0;
        count_r       <= '0;
        ext_r         <= '0;
        bytes_seen_r  <= 2'd0;
        first_slash_r <= 1'b0;
      end else begin
        dot_found_r   <= dot_found_nxt;
        zero_seen_r   <= zero_seen_nxt;
        count_r       <= count_nxt;
        ext_r         <= ext_nxt;
        bytes_seen_r  <= bytes_seen_nxt;
        first_slash_r <= first_slash_nxt;
      end
    end
  end

  a_dot_zero_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dot_found_r && zero_seen_r))
    else $error("dot and zero-byte flags both set");

  a_count_needs_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (dot_found_r && count_r <= uec_pkg::CNT_W'(uec_pkg::EXT_CAP)))
    else $error("capture count without a dot or beyond capacity");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> (count_r == '0 && !dot_found_r && bytes_seen_r == 2'd0))
    else $error("path state not cleared after last byte");

endmodule

/* sv/uec_match.sv */
// Table lookup of the captured extension, with the single-slash override.
// Depends on uec_pkg.
module uec_match (
  input  uec_pkg::cap_t cap,
  output logic [3:0]    file_type
);

  assign file_type = cap.single_slash ? uec_pkg::FT_HTML : uec_pkg::classify(cap.ext);

endmodule

/* sv/url_extension_classifier_unit.sv */
// URL extension classifier top level: one path byte per transaction, one
// file-type result per path. Depends on uec_pkg, uec_if, uec_capture, uec_match.
// Throughput: one path byte per cycle while no result is stalled at the output;
// the registered result frees the input, valid the cycle after the last byte.
// Reset: synchronous active-low rst_n clears all path state and the result valid.
module url_extension_classifier_unit (
  input  logic      clk,
  input  logic      rst_n,
  uec_path_if.sink  in_chan,
  uec_type_if.source out_chan
);

  logic          accept;
  uec_pkg::cap_t cap;
  logic [3:0]    type_comb;
  logic          out_valid_r;
  logic [3:0]    file_type_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  uec_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .path_byte (in_chan.path_byte),
    .last_byte (in_chan.last_byte),
    .cap       (cap)
  );

  uec_match u_match (
    .cap       (cap),
    .file_type (type_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_chan.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last_byte) begin
      file_type_r <= type_comb;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.file_type = file_type_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.last_byte) |=> out_valid_r)
    else $error("last byte did not produce a result");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (file_type_r <= uec_pkg::FT_TXT))
    else $error("file type code out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !accept)
    else $error("input accepted while result stalled");

endmodule
